### rtl/bsc_pkg.sv
// shared types and constants for the barometric compensation block
package bsc_pkg;
    localparam int unsigned CalSlots = 10;
    localparam logic [31:0] TCenter  = 32'd4000;
    localparam logic [31:0] B4Offset = 32'd32768;
    localparam logic [31:0] B7Scale  = 32'd50000;
    localparam logic [31:0] B7Limit  = 32'h8000_0000;

    localparam logic [2:0] CfgOss     = 3'd0;
    localparam logic [2:0] CfgGainSq  = 3'd1;
    localparam logic [2:0] CfgGainLin = 3'd2;
    localparam logic [2:0] CfgOffset  = 3'd3;
    localparam logic [2:0] CfgBias    = 3'd4;

    localparam logic [3:0] SlotAc1 = 4'd0;
    localparam logic [3:0] SlotAc2 = 4'd1;
    localparam logic [3:0] SlotAc3 = 4'd2;
    localparam logic [3:0] SlotAc4 = 4'd3;
    localparam logic [3:0] SlotAc5 = 4'd4;
    localparam logic [3:0] SlotAc6 = 4'd5;
    localparam logic [3:0] SlotB1  = 4'd6;
    localparam logic [3:0] SlotB2  = 4'd7;
    localparam logic [3:0] SlotMc  = 4'd8;
    localparam logic [3:0] SlotMd  = 4'd9;

    typedef struct packed {
        logic        action;
        logic [3:0]  coef_index;
        logic [15:0] coef_word;
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] pressure;
        logic               div_error;
    } t_out_word;

    typedef enum logic [5:0] {
        S_IDLE,
        S_T0, S_T1, S_T2, S_TDIV, S_T3,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_P9, S_PDIV, S_P10,
        S_Q0, S_Q1, S_Q2, S_Q3, S_Q4,
        S_DONE
    } t_state;
endpackage

### rtl/bsc_stream_if.sv
// valid/ready channel carrying one payload word
interface bsc_stream_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/bsc_divider.sv
// iterative 32-bit divider, unsigned core, signed wrapping
module bsc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_signed,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    logic [31:0] r_rem, n_rem, r_q, n_q, r_d, n_d;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [32:0] w_trial;
    logic [31:0] w_an, w_dn;

    assign w_an = (i_signed && i_num[31]) ? (32'd0 - i_num) : i_num;
    assign w_dn = (i_signed && i_den[31]) ? (32'd0 - i_den) : i_den;
    assign w_trial = {r_rem, r_q[31]} - {1'b0, r_d};
    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;

    always_comb begin
        n_rem = r_rem; n_q = r_q; n_d = r_d; n_cnt = r_cnt; n_neg = r_neg;
        if (i_start) begin
            n_rem = 32'd0; n_q = w_an; n_d = w_dn; n_cnt = 6'd32;
            n_neg = i_signed && (i_num[31] ^ i_den[31]);
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_q[31]};
                n_q = {r_q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_q <= n_q; r_d <= n_d; r_neg <= n_neg;
    end
endmodule

### rtl/barometric_sensor_compensation.sv
// Compensates raw temperature and pressure readings with a ten-word calibration table.
// A load word is taken and gives no result. A compute word runs through
// a sequencer that drives one shared 32x32 multiplier (one product a cycle) and a
// radix-2 divider of 32 steps; each of the two divisions holds the sequencer while
// the divider is started, runs its 32 steps and is seen idle again. Ready is
// low while a compute is under way or its result waits on the output register.
module barometric_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    bsc_stream_if.sink   i_in,
    bsc_stream_if.source o_out
);
    bsc_pkg::t_state r_state, n_state;
    logic [15:0] r_cal [bsc_pkg::CalSlots];
    logic [1:0]  r_oss;
    logic [31:0] r_gsq, r_glin, r_poff, r_bias;
    logic [15:0] r_ut;
    logic [18:0] r_up;
    logic [31:0] r_a, r_b, r_c, r_b6, r_sq, r_b3, r_b4, r_b7, r_p;
    logic [31:0] n_a, n_b, n_c, n_b6, n_sq, n_b3, n_b4, n_b7, n_p;
    logic [31:0] r_t, n_t;
    logic        r_err, n_err, r_ovalid, n_ovalid;
    logic [31:0] w_ma, w_mb, w_prod;
    logic        w_dstart, w_dsigned, w_dbusy;
    logic [31:0] w_dnum, w_dden, w_quot;
    logic [3:0]  w_rd;
    logic [31:0] w_cal;

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        asr = 32'($signed(v) >>> s);
    endfunction

    // calibration table read, one slot selected by the sequencer
    always_comb begin
        case (r_state)
            bsc_pkg::S_T0:  w_rd = bsc_pkg::SlotAc6;
            bsc_pkg::S_T1:  w_rd = bsc_pkg::SlotAc5;
            bsc_pkg::S_T2:  w_rd = bsc_pkg::SlotMd;
            bsc_pkg::S_TDIV: w_rd = bsc_pkg::SlotMc;
            bsc_pkg::S_P1:  w_rd = bsc_pkg::SlotB2;
            bsc_pkg::S_P2:  w_rd = bsc_pkg::SlotAc2;
            bsc_pkg::S_P3:  w_rd = bsc_pkg::SlotAc1;
            bsc_pkg::S_P4:  w_rd = bsc_pkg::SlotAc3;
            bsc_pkg::S_P5:  w_rd = bsc_pkg::SlotB1;
            bsc_pkg::S_P7:  w_rd = bsc_pkg::SlotAc4;
            default:        w_rd = bsc_pkg::SlotAc1;
        endcase
        if (w_rd == bsc_pkg::SlotAc4 || w_rd == bsc_pkg::SlotAc5 || w_rd == bsc_pkg::SlotAc6)
            w_cal = {16'd0, r_cal[w_rd]};
        else
            w_cal = {{16{r_cal[w_rd][15]}}, r_cal[w_rd]};
    end

    assign w_prod = 32'(w_ma * w_mb);

    bsc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_signed(w_dsigned),
        .i_num(w_dnum), .i_den(w_dden), .o_busy(w_dbusy), .o_quot(w_quot)
    );

    assign i_in.ready = (r_state == bsc_pkg::S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data.temperature = r_t;
    assign o_out.data.pressure = r_p;
    assign o_out.data.div_error = r_err;

    always_comb begin
        n_state = r_state; n_a = r_a; n_b = r_b; n_c = r_c; n_b6 = r_b6;
        n_sq = r_sq; n_b3 = r_b3; n_b4 = r_b4; n_b7 = r_b7; n_p = r_p; n_t = r_t;
        n_err = r_err; n_ovalid = r_ovalid;
        w_ma = r_a; w_mb = w_cal;
        w_dstart = 1'b0; w_dsigned = 1'b1; w_dnum = r_a; w_dden = r_b;
        if (o_out.valid && o_out.ready) n_ovalid = 1'b0;
        case (r_state)
            bsc_pkg::S_IDLE: begin
                if (i_in.valid && i_in.ready && i_in.data.action) n_state = bsc_pkg::S_T0;
            end
            bsc_pkg::S_T0: begin
                n_a = {16'd0, r_ut} - w_cal;
                n_state = bsc_pkg::S_T1;
            end
            bsc_pkg::S_T1: begin
                w_ma = r_a; w_mb = w_cal;
                n_a = asr(w_prod, 15);           // x1
                n_state = bsc_pkg::S_T2;
            end
            bsc_pkg::S_T2: begin
                n_b = r_a + w_cal;               // x1 + md
                if (r_a + w_cal == 32'd0) begin
                    n_t = 32'd0; n_p = 32'd0; n_err = 1'b1; n_state = bsc_pkg::S_DONE;
                end else begin
                    n_state = bsc_pkg::S_TDIV;
                end
            end
            bsc_pkg::S_TDIV: begin
                w_dstart = 1'b1; w_dnum = w_cal << 11; w_dden = r_b;
                n_state = bsc_pkg::S_T3;
            end
            bsc_pkg::S_T3: begin
                if (!w_dbusy) begin
                    n_t = asr(r_a + w_quot + 32'd8, 4);
                    n_b6 = r_a + w_quot - bsc_pkg::TCenter;
                    n_state = bsc_pkg::S_P0;
                end
            end
            bsc_pkg::S_P0: begin
                w_ma = r_b6; w_mb = r_b6;
                n_sq = asr(w_prod, 12);
                n_state = bsc_pkg::S_P1;
            end
            bsc_pkg::S_P1: begin
                w_ma = r_sq; w_mb = w_cal;
                n_a = asr(w_prod, 11);
                n_state = bsc_pkg::S_P2;
            end
            bsc_pkg::S_P2: begin
                w_ma = w_cal; w_mb = r_b6;
                n_a = r_a + asr(w_prod, 11);     // x3
                n_state = bsc_pkg::S_P3;
            end
            bsc_pkg::S_P3: begin
                n_b3 = asr(((w_cal << 2) + r_a << r_oss) + 32'd2, 2);
                n_state = bsc_pkg::S_P4;
            end
            bsc_pkg::S_P4: begin
                w_ma = w_cal; w_mb = r_b6;
                n_a = asr(w_prod, 13);
                n_state = bsc_pkg::S_P5;
            end
            bsc_pkg::S_P5: begin
                w_ma = w_cal; w_mb = r_sq;
                n_a = asr(r_a + asr(w_prod, 16) + 32'd2, 2);
                n_state = bsc_pkg::S_P7;
            end
            bsc_pkg::S_P7: begin
                w_ma = w_cal; w_mb = r_a + bsc_pkg::B4Offset;
                n_b4 = w_prod >> 15;
                n_state = bsc_pkg::S_P8;
            end
            bsc_pkg::S_P8: begin
                if (r_b4 == 32'd0) begin
                    n_t = 32'd0; n_p = 32'd0; n_err = 1'b1; n_state = bsc_pkg::S_DONE;
                end else begin
                    n_state = bsc_pkg::S_P9;
                end
            end
            bsc_pkg::S_P9: begin
                w_ma = {13'd0, r_up} - r_b3; w_mb = bsc_pkg::B7Scale >> r_oss;
                n_b7 = w_prod;
                n_state = bsc_pkg::S_PDIV;
            end
            bsc_pkg::S_PDIV: begin
                // small b7 doubles before the divide, large b7 after it
                w_dstart = 1'b1; w_dsigned = 1'b0; w_dden = r_b4;
                w_dnum = (r_b7 < bsc_pkg::B7Limit) ? (r_b7 << 1) : r_b7;
                n_state = bsc_pkg::S_P10;
            end
            bsc_pkg::S_P10: begin
                if (!w_dbusy) begin
                    n_p = (r_b7 < bsc_pkg::B7Limit) ? w_quot : (w_quot << 1);
                    n_state = bsc_pkg::S_Q0;
                end
            end
            bsc_pkg::S_Q0: begin
                w_ma = asr(r_p, 8); w_mb = asr(r_p, 8);
                n_a = w_prod;
                n_state = bsc_pkg::S_Q1;
            end
            bsc_pkg::S_Q1: begin
                w_ma = r_a; w_mb = r_gsq;
                n_a = asr(w_prod, 16);
                n_state = bsc_pkg::S_Q2;
            end
            bsc_pkg::S_Q2: begin
                w_ma = r_p; w_mb = r_glin;
                n_c = asr(w_prod, 16);
                n_state = bsc_pkg::S_Q3;
            end
            bsc_pkg::S_Q3: begin
                n_p = r_p + asr(r_a + r_c + r_poff, 4) + r_bias;
                n_err = 1'b0;
                n_state = bsc_pkg::S_DONE;
            end
            bsc_pkg::S_DONE: begin
                n_ovalid = 1'b1;
                n_state = bsc_pkg::S_IDLE;
            end
            default: n_state = bsc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsc_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_oss <= 2'd0;
            r_gsq <= 32'sd3038;
            r_glin <= -32'sd7357;
            r_poff <= 32'sd3791;
            r_bias <= 32'sd1600;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bsc_pkg::CfgOss:     r_oss <= i_cfg_data[1:0];
                    bsc_pkg::CfgGainSq:  r_gsq <= {{16{i_cfg_data[15]}}, i_cfg_data};
                    bsc_pkg::CfgGainLin: r_glin <= {{16{i_cfg_data[15]}}, i_cfg_data};
                    bsc_pkg::CfgOffset:  r_poff <= {{16{i_cfg_data[15]}}, i_cfg_data};
                    bsc_pkg::CfgBias:    r_bias <= {{16{i_cfg_data[15]}}, i_cfg_data};
                    default: ;
                endcase
            end
        end
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_b6 <= n_b6; r_sq <= n_sq;
        r_b3 <= n_b3; r_b4 <= n_b4; r_b7 <= n_b7; r_p <= n_p; r_t <= n_t; r_err <= n_err;
    end

    // calibration table and captured readings
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            if (!i_in.data.action && i_in.data.coef_index < 4'(bsc_pkg::CalSlots))
                r_cal[i_in.data.coef_index] <= i_in.data.coef_word;
            r_ut <= i_in.data.raw_temperature;
            r_up <= i_in.data.raw_pressure;
        end
    end
endmodule

### rtl/bsc_checker.sv
// port-level checks for the compensation block
module bsc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_ready,
    input logic o_valid,
    input logic o_ready,
    input logic o_err,
    input logic [31:0] o_t,
    input logic [31:0] o_p
);
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !i_ready) else $error("input taken while result pending");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_err) |-> (o_t == 32'd0 && o_p == 32'd0))
        else $error("error result not zeroed");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |=> (o_valid && $stable(o_p) && $stable(o_t)))
        else $error("stalled result changed");
endmodule

bind barometric_sensor_compensation bsc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ready(i_in.ready),
    .o_valid(o_out.valid), .o_ready(o_out.ready), .o_err(o_out.data.div_error),
    .o_t(o_out.data.temperature), .o_p(o_out.data.pressure)
);
